// ===== rtl/hms_pkg.sv =====
`default_nettype none

package hms_pkg;

  // Default list capacity
  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned DataW       = 32;

  // Input beat: one list element
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_beat_t;

  // Output beat: one sorted element
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_beat_t;

  // Strobes towards the two buffers (A holds the loaded list)
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_a;
    logic rd_b;
  } mem_ctl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // collect elements into buffer A
    ST_PAIR,   // set up a pair of runs, fetch first head
    ST_RDA,    // capture head of left run, fetch right head
    ST_RDB,    // capture head of right run
    ST_CMP,    // write the smaller head, fetch its successor
    ST_FILL,   // capture the refetched head
    ST_ORD,    // fetch next sorted element
    ST_OLD     // hand it to the output register
  } sort_state_e;

endpackage

`default_nettype wire

// ===== rtl/hms_ram.sv =====
`default_nettype none

module hms_ram #(
  parameter int unsigned Depth = hms_pkg::MaxItemsDef,
  parameter int unsigned AddrW = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AddrW-1:0]          waddr_i,
  input  wire logic [hms_pkg::DataW-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AddrW-1:0]          raddr_i,
  output logic      [hms_pkg::DataW-1:0] rdata_o
);
  import hms_pkg::*;

  logic [DataW-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hms_ctrl.sv =====
`default_nettype none

module hms_ctrl #(
  parameter int unsigned MaxItems = hms_pkg::MaxItemsDef,
  parameter int unsigned AddrW    = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire hms_pkg::in_beat_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output hms_pkg::out_beat_t             out_data_o,
  output hms_pkg::mem_ctl_t              mem_ctl_o,
  output logic      [AddrW-1:0]          waddr_o,
  output logic      [hms_pkg::DataW-1:0] wdata_o,
  output logic      [AddrW-1:0]          raddr_o,
  input  wire logic [hms_pkg::DataW-1:0] rdata_a_i,
  input  wire logic [hms_pkg::DataW-1:0] rdata_b_i
);
  import hms_pkg::*;

  // Count holds 0..MaxItems; pointer sums reach below three times that
  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned PtrW = CntW + 2;

  sort_state_e state_q, state_d;

  logic [CntW-1:0]         count_q, count_d;
  logic                    drop_q, drop_d;
  logic                    src_q, src_d;     // 0: A is source, B destination
  logic [PtrW-1:0]         w_q, w_d;
  logic [PtrW-1:0]         lo_q, lo_d;
  logic [PtrW-1:0]         mid_q, mid_d;
  logic [PtrW-1:0]         hi_q, hi_d;
  logic [PtrW-1:0]         a_q, a_d;
  logic [PtrW-1:0]         b_q, b_d;
  logic [PtrW-1:0]         k_q, k_d;
  logic signed [DataW-1:0] head_a_q, head_a_d;
  logic signed [DataW-1:0] head_b_q, head_b_d;
  logic                    took_b_q, took_b_d;
  logic                    ov_q, ov_d;
  out_beat_t               obuf_q, obuf_d;

  logic              in_acc, store_ok, list_end;
  logic [PtrW-1:0]   n_ext, n_new, lo_w, lo_2w, w_dbl, mid_calc, hi_calc;
  logic [PtrW-1:0]   a_inc, b_inc, k_inc, fetch_ptr;
  logic              a_ok, b_ok, take_b, pair_done, pass_done, sort_done;
  logic              fetch_ok, out_load, out_last;
  logic signed [DataW-1:0] src_rdata, taken;
  logic              rd_en, wr_en;
  logic [PtrW-1:0]   rd_ptr;

  // Shared arithmetic
  assign in_acc    = in_valid_i && in_ready_o;
  assign store_ok  = (count_q != CntW'(MaxItems));
  assign list_end  = in_acc && in_data_i.last;
  assign n_ext     = PtrW'(count_q);
  assign n_new     = n_ext + PtrW'(store_ok);
  assign lo_w      = lo_q + w_q;
  assign lo_2w     = lo_q + (w_q << 1);
  assign w_dbl     = w_q << 1;
  assign mid_calc  = (lo_w > n_ext) ? n_ext : lo_w;
  assign hi_calc   = (lo_2w > n_ext) ? n_ext : lo_2w;
  assign src_rdata = src_q ? rdata_b_i : rdata_a_i;

  // Merge decision: left run wins ties
  assign a_ok      = (a_q < mid_q);
  assign b_ok      = (b_q < hi_q);
  assign take_b    = b_ok && (!a_ok || (head_b_q < head_a_q));
  assign taken     = take_b ? head_b_q : head_a_q;
  assign a_inc     = a_q + 1'b1;
  assign b_inc     = b_q + 1'b1;
  assign k_inc     = k_q + 1'b1;
  assign fetch_ptr = take_b ? b_inc : a_inc;
  assign fetch_ok  = take_b ? (b_inc < hi_q) : (a_inc < mid_q);
  assign pair_done = (k_inc == hi_q);
  assign pass_done = (lo_2w >= n_ext);
  assign sort_done = (w_dbl >= n_ext);

  // Output register is free or drains this cycle
  assign out_load  = (state_q == ST_OLD) && (!ov_q || out_ready_i);
  assign out_last  = (k_inc == n_ext);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (list_end) begin
          state_d = (n_new > PtrW'(1)) ? ST_PAIR : ST_ORD;
        end
      end
      ST_PAIR: state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_CMP;
      ST_CMP: begin
        if (!pair_done) begin
          state_d = ST_FILL;
        end else if (!pass_done) begin
          state_d = ST_PAIR;
        end else if (!sort_done) begin
          state_d = ST_PAIR;
        end else begin
          state_d = ST_ORD;
        end
      end
      ST_FILL: state_d = ST_CMP;
      ST_ORD:  state_d = ST_OLD;
      ST_OLD: begin
        if (out_load) begin
          state_d = out_last ? ST_LOAD : ST_ORD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs: handshake and buffer strobes
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    rd_ptr     = '0;
    waddr_o    = k_q[AddrW-1:0];
    wdata_o    = taken;
    mem_ctl_o  = '0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        waddr_o    = count_q[AddrW-1:0];
        wdata_o    = in_data_i.value;
      end
      ST_PAIR: begin
        rd_en  = 1'b1;
        rd_ptr = lo_q;
      end
      ST_RDA: begin
        rd_en  = b_ok;
        rd_ptr = b_q;
      end
      ST_CMP: begin
        wr_en  = 1'b1;
        rd_en  = fetch_ok && !pair_done;
        rd_ptr = fetch_ptr;
      end
      ST_ORD: begin
        rd_en  = 1'b1;
        rd_ptr = k_q;
      end
      default: begin
      end
    endcase
    // Load always fills A; merges read the source and write the other buffer
    mem_ctl_o.wr_a = (in_acc && store_ok) || (wr_en && src_q);
    mem_ctl_o.wr_b = wr_en && !src_q;
    mem_ctl_o.rd_a = rd_en && !src_q;
    mem_ctl_o.rd_b = rd_en && src_q;
  end

  assign raddr_o = rd_ptr[AddrW-1:0];

  // Datapath next values
  always_comb begin
    count_d  = count_q;
    drop_d   = drop_q;
    src_d    = src_q;
    w_d      = w_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    hi_d     = hi_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    head_a_d = head_a_q;
    head_b_d = head_b_q;
    took_b_d = took_b_q;
    ov_d     = ov_q && !out_ready_i;
    obuf_d   = obuf_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            count_d = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last) begin
            src_d = 1'b0;
            w_d   = PtrW'(1);
            lo_d  = '0;
            k_d   = '0;
          end
        end
      end
      ST_PAIR: begin
        mid_d = mid_calc;
        hi_d  = hi_calc;
        a_d   = lo_q;
        b_d   = mid_calc;
        k_d   = lo_q;
      end
      ST_RDA: head_a_d = src_rdata;
      ST_RDB: head_b_d = src_rdata;
      ST_CMP: begin
        took_b_d = take_b;
        k_d      = k_inc;
        if (take_b) begin
          b_d = b_inc;
        end else begin
          a_d = a_inc;
        end
        if (pair_done) begin
          if (!pass_done) begin
            lo_d = lo_2w;
          end else begin
            src_d = !src_q;
            w_d   = w_dbl;
            lo_d  = '0;
            k_d   = '0;
          end
        end
      end
      ST_FILL: begin
        if (took_b_q) begin
          head_b_d = src_rdata;
        end else begin
          head_a_d = src_rdata;
        end
      end
      ST_OLD: begin
        if (out_load) begin
          ov_d                = 1'b1;
          obuf_d.sorted_value = src_rdata;
          obuf_d.last_out     = out_last;
          obuf_d.overflow     = drop_q;
          k_d                 = k_inc;
          if (out_last) begin
            count_d = '0;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      ov_q    <= 1'b0;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      ov_q    <= ov_d;
      src_q   <= src_d;
    end
  end

  // Pointers and payload
  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    lo_q     <= lo_d;
    mid_q    <= mid_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    k_q      <= k_d;
    head_a_q <= head_a_d;
    head_b_q <= head_b_d;
    took_b_q <= took_b_d;
    obuf_q   <= obuf_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = obuf_q;

endmodule

`default_nettype wire

// ===== rtl/hybrid_merge_sort_unit.sv =====
// Sorting unit for lists of signed 32-bit values.
// Input channel (in_valid_i/in_ready_o/in_data_i): one element per beat; a
// beat with last set closes the list. Up to MAX_ITEMS elements are kept;
// later ones are dropped and every result beat of that list has overflow set.
// Output channel (out_valid_o/out_ready_i/out_data_o): the stored elements in
// ascending order, one per beat, last_out on the final one.
// Loading accepts one element per cycle. Sorting runs ceil(log2 n) bottom-up
// merge passes between two buffers, each with one read and one write port;
// each run pair of a pass sets up, reads both run heads, then alternates
// writing the smaller head with refetching its successor (one buffer read per
// element; reads are registered). Output reads each element, then loads it
// into the output register.
// The input is not ready while a list is being sorted or emitted; it opens
// again once the final result sits in the output register.
// A stalled receiver holds the output register; the sequencer waits with
// the next element fetched. Reset returns to loading with an empty list;
// buffer contents are not cleared and are never read before being written.
`default_nettype none

module hybrid_merge_sort_unit #(
  parameter int unsigned MAX_ITEMS = hms_pkg::MaxItemsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hms_pkg::in_beat_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hms_pkg::out_beat_t     out_data_o
);
  import hms_pkg::*;

  localparam int unsigned AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata_a, rdata_b;

  // Sequencer with output register
  hms_ctrl #(
    .MaxItems (MAX_ITEMS),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  // Element buffer
  hms_ram #(
    .Depth (MAX_ITEMS),
    .AddrW (AddrW)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.wr_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_ctl.rd_a),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  // Scratch buffer
  hms_ram #(
    .Depth (MAX_ITEMS),
    .AddrW (AddrW)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.wr_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_ctl.rd_b),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  // A merge never reads and writes the same buffer in one cycle
  a_no_same_buf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((mem_ctl.wr_a && mem_ctl.rd_a) || (mem_ctl.wr_b && mem_ctl.rd_b)))
    else $error("read and write hit the same buffer");

  // No buffer reads while elements are being loaded
  a_no_read_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(mem_ctl.rd_a || mem_ctl.rd_b))
    else $error("buffer read during loading");

  // Addresses stay within capacity
  a_raddr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.rd_a || mem_ctl.rd_b) |-> (int'(raddr) < MAX_ITEMS))
    else $error("read address beyond capacity");

  a_waddr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.wr_a || mem_ctl.wr_b) |-> (int'(waddr) < MAX_ITEMS))
    else $error("write address beyond capacity");

  // A stalled result beat stays valid and unchanged until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while stalled");

endmodule

`default_nettype wire
